>>> design/pfd_pkg.sv
// Package for the PPM frame decoder: widths, register indexes and the
// command and status structs between the controller and the datapath.
// Used by pfd_ctrl, pfd_datapath and ppm_frame_decoder.
`timescale 1ns / 1ps
`default_nettype none
package pfd_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int TIME_BITS = 32;
	localparam int NCH_W     = 5;
	localparam int THR_W     = 16;
	localparam int PW_W      = 17;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THRESHOLD = 1'd1;

	localparam logic [NCH_W-1:0] RESET_CHANNELS = 5'd8;
	localparam logic [THR_W-1:0] RESET_SYNC_US  = 16'd5000;

	typedef struct packed {
		logic capture;
		logic rec_fall;
		logic start_frame;
		logic store_slot;
		logic emit_load;
	} cmd_t;

	typedef struct packed {
		logic is_rise;
		logic is_sync;
		logic can_store;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage
`default_nettype wire

>>> design/pfd_ctrl.sv
// Controller of the PPM frame decoder: accepts an edge item, evaluates it
// and sequences the emission of a frame. Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfd_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire pfd_pkg::status_t sts,
	output pfd_pkg::cmd_t        cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!sts.is_rise) begin
					cmd.rec_fall = 1'b1;
					state_nxt    = ST_IDLE;
				end else if (sts.is_sync) begin
					cmd.start_frame = 1'b1;
					state_nxt       = ST_EMIT;
				end else begin
					cmd.store_slot = sts.can_store;
					state_nxt      = ST_IDLE;
				end
			end
			ST_EMIT: begin
				// One slot goes to the output register whenever it is free.
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (sts.emit_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

>>> design/pfd_datapath.sv
// Datapath of the PPM frame decoder: configuration registers, edge timing,
// slot store, frame counter and the output register. Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfd_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pfd_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                             pin_level,
	input  wire logic [pfd_pkg::TIME_BITS-1:0]    time_us,
	input  wire pfd_pkg::cmd_t                    cmd,
	output pfd_pkg::status_t                      sts,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [pfd_pkg::SLOT_W-1:0]            slot_index,
	output logic signed [pfd_pkg::PW_W-1:0]       pulse_width_us,
	output logic [pfd_pkg::TIME_BITS-1:0]         frame_number,
	output logic                                  last_of_frame
);

	logic [pfd_pkg::NCH_W-1:0]     num_ch_q;
	logic [pfd_pkg::THR_W-1:0]     thr_q;
	logic                          cap_level_q;
	logic [pfd_pkg::TIME_BITS-1:0] cap_time_q;
	logic [pfd_pkg::TIME_BITS-1:0] fall_q;
	logic [pfd_pkg::TIME_BITS-1:0] frame_q;
	logic                          synced_q;
	logic [pfd_pkg::NCH_W-1:0]     pos_q;
	logic [pfd_pkg::THR_W-1:0]     store_q [pfd_pkg::MAX_SLOTS];
	logic [pfd_pkg::MAX_SLOTS-1:0] valid_q;
	logic [pfd_pkg::SLOT_W-1:0]    emit_idx_q;

	logic                          out_valid_q;
	logic [pfd_pkg::SLOT_W-1:0]    out_slot_q;
	logic [pfd_pkg::PW_W-1:0]      out_pw_q;
	logic [pfd_pkg::TIME_BITS-1:0] out_frame_q;
	logic                          out_last_q;

	logic [pfd_pkg::NCH_W-1:0]     active_n;
	logic [pfd_pkg::TIME_BITS-1:0] low_time;

	// A channel count of zero acts as one, and one above the store depth as the depth.
	always_comb begin
		priority if (num_ch_q == '0) begin
			active_n = pfd_pkg::NCH_W'(1);
		end else if (num_ch_q > pfd_pkg::NCH_W'(pfd_pkg::MAX_SLOTS)) begin
			active_n = pfd_pkg::NCH_W'(pfd_pkg::MAX_SLOTS);
		end else begin
			active_n = num_ch_q;
		end
	end

	// Low time wraps with the timestamp, so it is never negative.
	assign low_time = cap_time_q - fall_q;

	assign sts.is_rise   = cap_level_q;
	assign sts.is_sync   = low_time >
		{{(pfd_pkg::TIME_BITS - pfd_pkg::THR_W){1'b0}}, thr_q};
	assign sts.can_store = synced_q && (pos_q < active_n);
	assign sts.out_free  = !out_valid_q || !out_stall;
	assign sts.emit_last = ({1'b0, emit_idx_q} == (active_n - pfd_pkg::NCH_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch_q <= pfd_pkg::RESET_CHANNELS;
			thr_q    <= pfd_pkg::RESET_SYNC_US;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfd_pkg::CFG_NUM_CHANNELS: begin
					num_ch_q <= cfg_data[pfd_pkg::NCH_W-1:0];
				end
				pfd_pkg::CFG_SYNC_THRESHOLD: begin
					thr_q <= cfg_data[pfd_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cap_level_q <= pin_level;
			cap_time_q  <= time_us;
		end
		if (cmd.store_slot) begin
			store_q[pos_q[pfd_pkg::SLOT_W-1:0]] <= low_time[pfd_pkg::THR_W-1:0];
		end
		if (cmd.emit_load) begin
			out_slot_q  <= emit_idx_q;
			// A slot never captured reads as minus one.
			out_pw_q    <= valid_q[emit_idx_q] ? {1'b0, store_q[emit_idx_q]} : '1;
			out_frame_q <= frame_q;
			out_last_q  <= sts.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_q      <= '0;
			frame_q     <= '0;
			synced_q    <= 1'b0;
			pos_q       <= '0;
			valid_q     <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rec_fall) begin
				fall_q <= cap_time_q;
			end
			if (cmd.start_frame) begin
				frame_q    <= frame_q + pfd_pkg::TIME_BITS'(1);
				synced_q   <= 1'b1;
				pos_q      <= '0;
				emit_idx_q <= '0;
			end
			if (cmd.store_slot) begin
				valid_q[pos_q[pfd_pkg::SLOT_W-1:0]] <= 1'b1;
				pos_q <= pos_q + pfd_pkg::NCH_W'(1);
			end
			if (cmd.emit_load) begin
				emit_idx_q  <= emit_idx_q + pfd_pkg::SLOT_W'(1);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign slot_index     = out_slot_q;
	assign pulse_width_us = out_pw_q;
	assign frame_number   = out_frame_q;
	assign last_of_frame  = out_last_q;

endmodule
`default_nettype wire

>>> design/ppm_frame_decoder.sv
// Top level of the PPM frame decoder: joins the controller and the datapath.
// Depends on pfd_pkg, pfd_ctrl and pfd_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall   | pin_level, time_us
//   out     | out_valid / out_stall | slot_index, pulse_width_us, frame_number,
//           |                       | last_of_frame
//   cfg     | cfg_we                | cfg_index, cfg_data
//
// A falling edge or a rising edge without sync is accepted, then evaluated.
// A sync edge is accepted, evaluated, then emits one item per active slot through the
// single output register, which the emission sequence fills once per cycle unless stalled.
// A stall on the output holds the sequence; no input item is taken meanwhile.
// After reset all slots read as minus one; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module ppm_frame_decoder (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pfd_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             pin_level,
	input  wire logic [pfd_pkg::TIME_BITS-1:0]    time_us,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [pfd_pkg::SLOT_W-1:0]            slot_index,
	output logic signed [pfd_pkg::PW_W-1:0]       pulse_width_us,
	output logic [pfd_pkg::TIME_BITS-1:0]         frame_number,
	output logic                                  last_of_frame
);

	pfd_pkg::cmd_t    cmd;
	pfd_pkg::status_t sts;

	pfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfd_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pin_level      (pin_level),
		.time_us        (time_us),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.slot_index     (slot_index),
		.pulse_width_us (pulse_width_us),
		.frame_number   (frame_number),
		.last_of_frame  (last_of_frame)
	);

endmodule
`default_nettype wire

>>> design/pfd_checker.sv
// Port checker for the PPM frame decoder, bound to the top level.
// Depends on pfd_pkg and ppm_frame_decoder.
`timescale 1ns / 1ps
`default_nettype none
module pfd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [pfd_pkg::SLOT_W-1:0]    slot_index,
	input wire logic [pfd_pkg::PW_W-1:0]      pulse_width_us,
	input wire logic [pfd_pkg::TIME_BITS-1:0] frame_number,
	input wire logic                          last_of_frame
);

	// A stalled result item holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot_index) &&
		$stable(pulse_width_us) && $stable(frame_number) && $stable(last_of_frame))
		else $error("stalled result item changed");

	// The top slot is always the end of a run.
	a_top_slot_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_frame |-> slot_index != '1)
		else $error("top slot emitted without end marker");

	// Within a run the next slot follows at once, in the same frame.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_frame |=> out_valid &&
		slot_index == $past(slot_index) + pfd_pkg::SLOT_W'(1) &&
		frame_number == $past(frame_number))
		else $error("frame run broken");

	// An accepted item is evaluated before another is taken.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while evaluating");

endmodule

bind ppm_frame_decoder pfd_checker u_pfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.slot_index     (slot_index),
	.pulse_width_us (pulse_width_us),
	.frame_number   (frame_number),
	.last_of_frame  (last_of_frame)
);
`default_nettype wire

>>> tb/ppm_frame_checker.sv
// Checker for the PPM frame decoder: watches the register port and both item
// channels, predicts the slot values each edge causes and compares them.
// Depends on pfd_pkg.
`timescale 1ns / 1ps
module ppm_frame_checker
	import pfd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic                  pin_level,
	input  wire logic [TIME_BITS-1:0]  time_us,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [SLOT_W-1:0]     slot_index,
	input  wire logic signed [PW_W-1:0] pulse_width_us,
	input  wire logic [TIME_BITS-1:0]  frame_number,
	input  wire logic                  last_of_frame,
	output int                         mismatches,
	output int                         results_due
);

	typedef struct packed {
		logic [SLOT_W-1:0]      slot;
		logic signed [PW_W-1:0] width;
		logic [TIME_BITS-1:0]   frame;
		logic                   last;
	} slot_value_t;

	logic [NCH_W-1:0]       chan_reg;
	logic [THR_W-1:0]       thr_reg;
	logic [TIME_BITS-1:0]   fall_time;
	logic                   synced;
	logic [5:0]             slot_pos;
	logic [TIME_BITS-1:0]   frames;
	logic signed [PW_W-1:0] widths [MAX_SLOTS];
	slot_value_t            values_due [$];
	slot_value_t            want;

	function automatic int active_slots(input logic [NCH_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > MAX_SLOTS)
			return MAX_SLOTS;
		return int'(n);
	endfunction

	task automatic decode_edge(input logic rising, input logic [TIME_BITS-1:0] t);
		logic [TIME_BITS-1:0] low;
		int n;
		slot_value_t v;
		if (!rising) begin
			fall_time = t;
			return;
		end
		// Modulo subtraction: a rise stamped before its fall gives a huge low time.
		low = t - fall_time;
		n = active_slots(chan_reg);
		if (low > {{(TIME_BITS-THR_W){1'b0}}, thr_reg}) begin
			synced = 1'b1;
			slot_pos = '0;
			frames = frames + 1'b1;
			for (int i = 0; i < n; i++) begin
				v.slot = SLOT_W'(i);
				v.width = widths[i];
				v.frame = frames;
				v.last = (i == n - 1);
				values_due.push_back(v);
			end
		end else if (synced && slot_pos < n) begin
			widths[slot_pos] = low[PW_W-1:0];
			slot_pos = slot_pos + 1'b1;
		end
	endtask

	task automatic compare_field(input string name, input longint exp_val, input longint got);
		if (exp_val != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $realtime, name, exp_val, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_reg = RESET_CHANNELS;
			thr_reg = RESET_SYNC_US;
			fall_time = '0;
			synced = 1'b0;
			slot_pos = '0;
			frames = '0;
			foreach (widths[i])
				widths[i] = '1;
			values_due.delete();
			mismatches = 0;
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NUM_CHANNELS:   chan_reg = cfg_data[NCH_W-1:0];
					CFG_SYNC_THRESHOLD: thr_reg = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				decode_edge(pin_level, time_us);
			if (out_valid && !out_stall) begin
				if (values_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected item: slot %0d width %0d frame %0d last %0b",
						$realtime, slot_index, pulse_width_us, frame_number, last_of_frame);
				end else begin
					want = values_due.pop_front();
					compare_field("slot_index", want.slot, slot_index);
					compare_field("pulse_width_us", $signed(want.width), $signed(pulse_width_us));
					compare_field("frame_number", want.frame, frame_number);
					compare_field("last_of_frame", want.last, last_of_frame);
				end
			end
			results_due <= values_due.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Top of the PPM frame decoder testbench: clock, reset, edge stimulus,
// register writes and the verdict. Depends on pfd_pkg, ppm_frame_decoder
// and ppm_frame_checker.
`timescale 1ns / 1ps
module tb_top;
	import pfd_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int END_CYCLES      = 24;
	localparam int PHASES          = 7;
	localparam int EDGES_PER_PHASE = 35;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_NUM_CHANNELS;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   pin_level = 1'b0;
	logic [TIME_BITS-1:0]   time_us = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [SLOT_W-1:0]      slot_index;
	logic signed [PW_W-1:0] pulse_width_us;
	logic [TIME_BITS-1:0]   frame_number;
	logic                   last_of_frame;

	int mismatches;
	int results_due;
	int stall_left = 0;
	int idle_cycles = 0;
	int edges_sent = 0;
	logic quiet = 1'b0;

	logic [NCH_W-1:0]     cur_nch = RESET_CHANNELS;
	logic [THR_W-1:0]     cur_thr = RESET_SYNC_US;
	logic [TIME_BITS-1:0] clock_us = '0;

	ppm_frame_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pin_level(pin_level), .time_us(time_us),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot_index(slot_index), .pulse_width_us(pulse_width_us),
		.frame_number(frame_number), .last_of_frame(last_of_frame)
	);

	ppm_frame_checker frame_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pin_level(pin_level), .time_us(time_us),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot_index(slot_index), .pulse_width_us(pulse_width_us),
		.frame_number(frame_number), .last_of_frame(last_of_frame),
		.mismatches(mismatches), .results_due(results_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Random output back-pressure in bursts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Presents one edge item and returns at the edge that accepts it.
	task automatic send_edge(input logic rising, input logic [TIME_BITS-1:0] t);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pin_level <= rising;
		time_us <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		edges_sent++;
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [NCH_W-1:0] nch, input logic [THR_W-1:0] thr);
		logic [CFG_W-1:0] word;
		word = CFG_W'($urandom());
		word[NCH_W-1:0] = nch;
		cfg_we <= 1'b1;
		cfg_index <= CFG_NUM_CHANNELS;
		cfg_data <= word;
		@(posedge clk);
		cfg_index <= CFG_SYNC_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_nch = nch;
		cur_thr = thr;
	endtask

	task automatic low_pulse(input logic [TIME_BITS-1:0] low);
		send_edge(1'b0, clock_us);
		clock_us += low;
		send_edge(1'b1, clock_us);
		clock_us += $urandom_range(1, 600);
	endtask

	// A sync gap followed by channel pulses, sometimes too few or too many.
	task automatic ppm_frame();
		int slots;
		int pulses;
		logic [TIME_BITS-1:0] low;
		slots = (cur_nch == 0) ? 1 : ((cur_nch > MAX_SLOTS) ? MAX_SLOTS : int'(cur_nch));
		low = {16'd0, cur_thr} + 32'd1 + $urandom_range(0, 3000);
		low_pulse(low);
		pulses = ($urandom_range(0, 3) == 0) ? $urandom_range(0, slots + 2) : slots;
		repeat (pulses) begin
			case ($urandom_range(0, 7))
				0:       low = '0;
				1:       low = {16'd0, cur_thr};
				default: low = $urandom_range(0, cur_thr);
			endcase
			low_pulse(low);
		end
	endtask

	task automatic broken_sequence();
		case ($urandom_range(0, 2))
			0: begin
				send_edge(1'b0, clock_us);
				send_edge(1'b1, clock_us - $urandom_range(1, 1000));
			end
			1: begin
				send_edge(1'b0, clock_us);
				clock_us += $urandom_range(0, 400);
				low_pulse($urandom_range(0, cur_thr));
			end
			default: begin
				low_pulse($urandom_range(0, cur_thr));
				send_edge(1'b1, clock_us);
			end
		endcase
		clock_us += $urandom_range(1, 600);
	endtask

	initial begin
		int target;
		logic [NCH_W-1:0] nch;
		logic [THR_W-1:0] thr;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a rise before any sync is dropped, then a sync shows
		// all slots invalid, followed by zero, threshold and wrapped low times.
		send_edge(1'b1, 32'd100);
		send_edge(1'b0, 32'd200);
		send_edge(1'b1, 32'd5201);
		send_edge(1'b0, 32'd6000);
		send_edge(1'b1, 32'd6000);
		send_edge(1'b0, 32'd7000);
		send_edge(1'b1, 32'd12000);
		send_edge(1'b0, 32'hFFFF_FFF0);
		send_edge(1'b1, 32'h0000_0010);
		// A rise stamped before its fall counts as a sync.
		send_edge(1'b0, 32'h8000_0000);
		send_edge(1'b1, 32'h7FFF_FFFF);
		send_edge(1'b0, 32'hFFFF_FFFF);
		send_edge(1'b1, 32'h0000_0000);
		wait_results_drained();

		// One slot, zero threshold: the second pulse finds the slot index full.
		set_config(5'd1, 16'd0);
		send_edge(1'b0, 32'd0);
		send_edge(1'b1, 32'd1);
		send_edge(1'b0, 32'd10);
		send_edge(1'b1, 32'd10);
		send_edge(1'b0, 32'd20);
		send_edge(1'b1, 32'd20);
		send_edge(1'b0, 32'd30);
		send_edge(1'b1, 32'd31);

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_results_drained();
			case (phase)
				0: begin nch = 5'd16; thr = 16'hFFFF; end
				1: begin nch = 5'd0;  thr = THR_W'($urandom_range(200, 3000)); end
				2: begin nch = 5'd31; thr = THR_W'($urandom_range(0, 65535)); end
				3: begin nch = 5'd1;  thr = THR_W'($urandom_range(0, 50)); end
				default: begin
					nch = NCH_W'($urandom_range(0, 31));
					thr = ($urandom_range(0, 1) == 0) ? THR_W'($urandom_range(0, 65535))
					                                  : THR_W'($urandom_range(300, 5000));
				end
			endcase
			set_config(nch, thr);
			if (phase == PHASES - 1)
				quiet <= 1'b1;
			clock_us = $urandom();
			target = edges_sent + EDGES_PER_PHASE;
			while (edges_sent < target) begin
				case ($urandom_range(0, 11))
					0: repeat ($urandom_range(1, 4))
						send_edge(1'($urandom_range(0, 1)), $urandom());
					1: broken_sequence();
					2: wait_results_drained();
					default: ppm_frame();
				endcase
			end
		end

		wait_results_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
